[sv/aoq_pkg.sv]
// Package with the shared types and constants of the bounding box overlap query table.
package aoq_pkg;

  localparam int MAX_BOXES  = 32;
  localparam int COORD_BITS = 24;
  localparam int HALF_BITS  = COORD_BITS - 1;
  localparam int IDX_W      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int OUT_IDX_W  = 5;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_VERTEX = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]                    req_type;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic signed [COORD_BITS-1:0]  coord_z;
    logic [HALF_BITS-1:0]          half_x;
    logic [HALF_BITS-1:0]          half_y;
    logic [HALF_BITS-1:0]          half_z;
    logic                          final_vertex;
  } req_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] box_index;
    logic                 hit;
    logic                 last;
    logic                 overflowed;
  } res_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] min_z;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] max_y;
    logic signed [COORD_BITS-1:0] max_z;
  } box_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic step;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic scan_more;
    logic tvalid;
    logic hit_now;
    logic pend;
    logic out_free;
  } status_t;

endpackage

[sv/aabb_overlap_query_table_unit.sv]
// Top level of the bounding box overlap query table: controller and datapath joined.
//
//   channel  payload          valid       stall       direction
//   req      aoq_pkg::req_t   req_valid   req_stall   into the block
//   res      aoq_pkg::res_t   res_valid   res_stall   out of the block
//
// Clear and vertex transfers produce no result.
// A query holds the request side stalled until its final result is loaded into the result
// register; the scan reads one stored box per cycle from the table memory while it is not paused.
// A hit is held back until the next hit or the end of the scan so that the final result can carry last.
// Reset empties the table; box storage itself is not cleared.
// A stalled result register pauses the scan when a second hit is ready.
module aabb_overlap_query_table_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  aoq_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output aoq_pkg::res_t res
);

  aoq_pkg::cmd_t    cmd;
  aoq_pkg::status_t status;

  aoq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .status    (status),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  aoq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .res_stall (res_stall),
    .status    (status),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

[sv/aoq_ctrl.sv]
// Controller state machine that sequences item loads and table scans.
module aoq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [1:0]      req_type,
  input  aoq_pkg::status_t status,
  output logic            req_stall,
  output aoq_pkg::cmd_t   cmd
);

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t state;
  logic   accept;
  logic   blocked;

  always_comb begin
    accept  = req_valid && !req_stall;
    blocked = status.hit_now && status.pend && !status.out_free;
    cmd.load       = accept;
    cmd.scan_init  = accept && (req_type == aoq_pkg::REQ_QUERY);
    cmd.step       = (state == SCAN) && !blocked && (status.tvalid || status.scan_more);
    cmd.emit_final = (state == SCAN) && !status.tvalid && !status.scan_more &&
                     status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      req_stall <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (accept && (req_type == aoq_pkg::REQ_QUERY)) begin
            state     <= SCAN;
            req_stall <= 1'b1;
          end
        end
        SCAN: begin
          if (cmd.emit_final) begin
            state     <= IDLE;
            req_stall <= 1'b0;
          end
        end
        default: begin
          state     <= IDLE;
          req_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

[sv/aoq_datapath.sv]
// Datapath with the box table memory, polygon accumulator, query bounds and result register.
module aoq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  aoq_pkg::req_t     req,
  input  aoq_pkg::cmd_t     cmd,
  input  logic              res_stall,
  output aoq_pkg::status_t  status,
  output logic              res_valid,
  output aoq_pkg::res_t     res
);

  localparam int CW = aoq_pkg::COORD_BITS;

  aoq_pkg::box_t                 table_mem [aoq_pkg::MAX_BOXES];
  aoq_pkg::box_t                 rd_data;
  aoq_pkg::box_t                 acc;
  aoq_pkg::box_t                 acc_next;
  logic [aoq_pkg::CNT_W-1:0]     box_count;
  logic                          polygon_open;
  logic                          overflow_flag;
  logic                          room;
  logic signed [CW:0]            lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic [aoq_pkg::CNT_W-1:0]     fidx;
  logic [aoq_pkg::IDX_W-1:0]     tidx;
  logic                          tvalid;
  logic                          pend;
  logic [aoq_pkg::IDX_W-1:0]     pend_idx;
  logic                          overlap;
  logic                          is_vertex;
  logic                          is_query;
  logic                          push;

  function automatic logic signed [CW:0] ext(input logic signed [CW-1:0] v);
    ext = (CW+1)'(v);
  endfunction

  function automatic logic apart(input logic signed [CW:0] qlo, input logic signed [CW:0] qhi,
                                 input logic signed [CW:0] blo, input logic signed [CW:0] bhi);
    apart = (qlo > bhi) || (blo > qhi);
  endfunction

  always_comb begin
    room      = box_count < aoq_pkg::CNT_W'(aoq_pkg::MAX_BOXES);
    is_vertex = cmd.load && (req.req_type == aoq_pkg::REQ_VERTEX);
    is_query  = cmd.load && (req.req_type == aoq_pkg::REQ_QUERY);
    if (!polygon_open) begin
      acc_next.min_x = req.coord_x;
      acc_next.min_y = req.coord_y;
      acc_next.min_z = req.coord_z;
      acc_next.max_x = req.coord_x;
      acc_next.max_y = req.coord_y;
      acc_next.max_z = req.coord_z;
    end else begin
      acc_next.min_x = (req.coord_x < acc.min_x) ? req.coord_x : acc.min_x;
      acc_next.min_y = (req.coord_y < acc.min_y) ? req.coord_y : acc.min_y;
      acc_next.min_z = (req.coord_z < acc.min_z) ? req.coord_z : acc.min_z;
      acc_next.max_x = (req.coord_x > acc.max_x) ? req.coord_x : acc.max_x;
      acc_next.max_y = (req.coord_y > acc.max_y) ? req.coord_y : acc.max_y;
      acc_next.max_z = (req.coord_z > acc.max_z) ? req.coord_z : acc.max_z;
    end
    overlap = !(apart(lo_x, hi_x, ext(rd_data.min_x), ext(rd_data.max_x)) ||
                apart(lo_y, hi_y, ext(rd_data.min_y), ext(rd_data.max_y)) ||
                apart(lo_z, hi_z, ext(rd_data.min_z), ext(rd_data.max_z)));
    push = cmd.step && tvalid && overlap && pend;
    status.scan_more = fidx < box_count;
    status.tvalid    = tvalid;
    status.hit_now   = tvalid && overlap;
    status.pend      = pend;
    status.out_free  = !res_valid || !res_stall;
  end

  always_ff @(posedge clk) begin
    if (is_vertex && room && req.final_vertex) begin
      table_mem[box_count[aoq_pkg::IDX_W-1:0]] <= acc_next;
    end
    if (cmd.step && status.scan_more) begin
      rd_data <= table_mem[fidx[aoq_pkg::IDX_W-1:0]];
      tidx    <= fidx[aoq_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (is_vertex) begin
      acc <= acc_next;
    end
    if (is_query) begin
      lo_x <= ext(req.coord_x) - (CW+1)'(req.half_x);
      lo_y <= ext(req.coord_y) - (CW+1)'(req.half_y);
      lo_z <= ext(req.coord_z) - (CW+1)'(req.half_z);
      hi_x <= ext(req.coord_x) + (CW+1)'(req.half_x);
      hi_y <= ext(req.coord_y) + (CW+1)'(req.half_y);
      hi_z <= ext(req.coord_z) + (CW+1)'(req.half_z);
    end
    if (cmd.step && tvalid && overlap) begin
      pend_idx <= tidx;
    end
    if (push) begin
      res.box_index  <= aoq_pkg::OUT_IDX_W'(pend_idx);
      res.hit        <= 1'b1;
      res.last       <= 1'b0;
      res.overflowed <= overflow_flag;
    end else if (cmd.emit_final) begin
      res.box_index  <= pend ? aoq_pkg::OUT_IDX_W'(pend_idx) : '0;
      res.hit        <= pend;
      res.last       <= 1'b1;
      res.overflowed <= overflow_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_count     <= '0;
      polygon_open  <= 1'b0;
      overflow_flag <= 1'b0;
      fidx          <= '0;
      tvalid        <= 1'b0;
      pend          <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cmd.load && (req.req_type == aoq_pkg::REQ_CLEAR)) begin
        box_count     <= '0;
        polygon_open  <= 1'b0;
        overflow_flag <= 1'b0;
      end
      if (is_vertex) begin
        if (!polygon_open && !room) begin
          overflow_flag <= 1'b1;
        end
        if (req.final_vertex && room) begin
          box_count <= box_count + 1'b1;
        end
        polygon_open <= !req.final_vertex;
      end
      if (cmd.scan_init) begin
        fidx   <= '0;
        tvalid <= 1'b0;
        pend   <= 1'b0;
      end else if (cmd.step) begin
        if (status.scan_more) begin
          fidx <= fidx + 1'b1;
        end
        tvalid <= status.scan_more;
        if (tvalid && overlap) begin
          pend <= 1'b1;
        end
      end else if (cmd.emit_final) begin
        pend <= 1'b0;
      end
      if (push || cmd.emit_final) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
